[sv/lzb_pkg.sv]
// lzb_pkg: shared types and constants for the LZ back-reference byte decompressor.
// No dependencies; used by every module of the block except lzb_ram.
`timescale 1ns / 1ps

package lzb_pkg;

  localparam int OUT_LANES   = 4;
  localparam int LANE_IW     = $clog2(OUT_LANES);
  localparam int CNT_W       = $clog2(OUT_LANES + 1);
  localparam int OUT_TDATA_W = ((OUT_LANES * 8 + CNT_W + 7) / 8) * 8;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  localparam int         REF_FLAG_BIT = 7;
  localparam logic [7:0] LOW7         = 8'h7F;
  localparam logic [7:0] PRODUCED_SAT = 8'd128;

  localparam int TUSER_DONE  = 0;
  localparam int TUSER_TRUNC = 1;

  typedef logic [OUT_LANES-1:0][7:0] lane_vec_t;

  typedef struct packed {
    logic       put_lit;
    logic       emit;
    logic       res_done;
    logic       res_trunc;
    logic       copy_start;
    logic [6:0] offset;
    logic       issue;
    logic       flush_final;
    logic       restart;
  } lzb_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       d_vld;
    logic       consume;
    logic [7:0] produced;
  } lzb_sts_t;

endpackage

[sv/lzb_ram.sv]
// lzb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/lzb_ctrl.sv]
// lzb_ctrl: token parser and copy sequencer of the decompressor.
// Depends on lzb_pkg; drives lzb_datapath through lzb_cmd_t.
`timescale 1ns / 1ps

module lzb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  input  lzb_pkg::lzb_sts_t sts,
  output lzb_pkg::lzb_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_COPY   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [6:0] ref_offset, ref_offset_next;
  logic [6:0] lits, lits_next;
  logic [7:0] rem, rem_next;
  logic       end_lat, end_lat_next;
  logic       accept;
  logic       copy_ok;

  assign in_ready = (state == ST_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;
  assign copy_ok  = (ref_offset != 7'd0) && (sts.produced >= {1'b0, ref_offset})
                    && (in_byte != 8'd0);

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    ref_offset_next = ref_offset;
    lits_next       = lits;
    rem_next        = rem;
    end_lat_next    = end_lat;
    cmd             = '0;
    cmd.offset      = ref_offset;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (phase)
            lzb_pkg::PH_LITERAL: begin
              cmd.put_lit = 1'b1;
              cmd.emit    = 1'b1;
              lits_next   = (lits != 7'd0) ? lits - 7'd1 : lits;
              phase_next  = (lits_next == 7'd0) ? lzb_pkg::PH_HEADER : lzb_pkg::PH_LITERAL;
            end
            lzb_pkg::PH_COUNT: begin
              phase_next = lzb_pkg::PH_HEADER;
              if (copy_ok) begin
                cmd.copy_start = 1'b1;
                rem_next       = in_byte;
                end_lat_next   = in_end;
                state_next     = ST_COPY;
              end
            end
            default: begin
              if (in_byte[lzb_pkg::REF_FLAG_BIT]) begin
                ref_offset_next = 7'(in_byte & lzb_pkg::LOW7);
                phase_next      = lzb_pkg::PH_COUNT;
              end else if (in_byte != 8'd0) begin
                lits_next  = 7'(in_byte & lzb_pkg::LOW7);
                phase_next = lzb_pkg::PH_LITERAL;
              end
            end
          endcase
          if (in_end && state_next == ST_IDLE) begin
            cmd.emit        = 1'b1;
            cmd.res_done    = 1'b1;
            cmd.res_trunc   = (phase_next != lzb_pkg::PH_HEADER);
            cmd.restart     = 1'b1;
            phase_next      = lzb_pkg::PH_HEADER;
            ref_offset_next = 7'd0;
            lits_next       = 7'd0;
          end
        end
      end
      ST_COPY: begin
        cmd.issue = (rem != 8'd0) && (!sts.d_vld || sts.consume);
        if (cmd.issue) begin
          rem_next = rem - 8'd1;
        end
        if (rem == 8'd0 && !sts.d_vld) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.flush_final = 1'b1;
          cmd.res_done    = end_lat;
          if (end_lat) begin
            cmd.restart     = 1'b1;
            phase_next      = lzb_pkg::PH_HEADER;
            ref_offset_next = 7'd0;
            lits_next       = 7'd0;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= lzb_pkg::PH_HEADER;
      ref_offset <= 7'd0;
      lits       <= 7'd0;
      rem        <= 8'd0;
      end_lat    <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      ref_offset <= ref_offset_next;
      lits       <= lits_next;
      rem        <= rem_next;
      end_lat    <= end_lat_next;
    end
  end

endmodule

[sv/lzb_datapath.sv]
// lzb_datapath: history RAM, write/read pointers, lane packer and result register.
// Depends on lzb_pkg and lzb_ram; controlled by lzb_ctrl.
`timescale 1ns / 1ps

module lzb_datapath #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      in_byte,
  input  lzb_pkg::lzb_cmd_t               cmd,
  output lzb_pkg::lzb_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lzb_pkg::lane_vec_t              out_lanes,
  output logic [lzb_pkg::CNT_W-1:0]       out_cnt,
  output logic                            out_last,
  output logic                            out_done,
  output logic                            out_trunc
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [lzb_pkg::CNT_W-1:0] FULL = lzb_pkg::CNT_W'(lzb_pkg::OUT_LANES);
  localparam int PAD_W = (lzb_pkg::OUT_LANES - 1) * 8;

  logic [AW-1:0]               wp;
  logic [AW-1:0]               rp;
  logic [AW-1:0]               rp_start;
  logic [AW-1:0]               off_ext;
  logic [7:0]                  produced;
  logic                        d_vld;
  logic                        fwd;
  logic [7:0]                  fwd_data;
  logic [7:0]                  ram_q;
  logic [7:0]                  cp_byte;
  lzb_pkg::lane_vec_t          pack;
  logic [lzb_pkg::CNT_W-1:0]   pack_cnt;
  logic                        out_free;
  logic                        consume;
  logic                        flush_mid;
  logic                        we;
  logic [7:0]                  wdata;

  assign out_free  = !out_valid || out_ready;
  assign consume   = d_vld && ((pack_cnt < FULL) || out_free);
  assign flush_mid = d_vld && (pack_cnt == FULL) && out_free;
  assign cp_byte   = fwd ? fwd_data : ram_q;
  assign we        = cmd.put_lit || consume;
  assign wdata     = cmd.put_lit ? in_byte : cp_byte;
  assign off_ext   = AW'(cmd.offset);
  assign rp_start  = (wp >= off_ext) ? (wp - off_ext)
                   : AW'({1'b0, wp} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, off_ext});

  assign sts.out_free = out_free;
  assign sts.d_vld    = d_vld;
  assign sts.consume  = consume;
  assign sts.produced = produced;

  lzb_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (wdata),
    .re    (cmd.issue),
    .raddr (rp),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      produced <= 8'd0;
      d_vld    <= 1'b0;
      pack     <= '0;
      pack_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.restart) begin
        wp       <= '0;
        produced <= 8'd0;
      end else if (we) begin
        wp <= (wp == LAST_ADDR) ? '0 : wp + AW'(1);
        if (produced < lzb_pkg::PRODUCED_SAT) begin
          produced <= produced + 8'd1;
        end
      end

      if (cmd.issue) begin
        d_vld <= 1'b1;
      end else if (consume) begin
        d_vld <= 1'b0;
      end

      if (consume) begin
        if (pack_cnt == FULL) begin
          pack     <= {{PAD_W{1'b0}}, cp_byte};
          pack_cnt <= lzb_pkg::CNT_W'(1);
        end else begin
          pack[pack_cnt[lzb_pkg::LANE_IW-1:0]] <= cp_byte;
          pack_cnt <= pack_cnt + lzb_pkg::CNT_W'(1);
        end
      end else if (cmd.flush_final) begin
        pack     <= '0;
        pack_cnt <= '0;
      end

      if (flush_mid || cmd.flush_final || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_start) begin
      rp <= rp_start;
    end else if (cmd.issue) begin
      rp <= (rp == LAST_ADDR) ? '0 : rp + AW'(1);
    end

    if (cmd.issue) begin
      fwd      <= consume && (rp == wp);
      fwd_data <= cp_byte;
    end

    if (flush_mid) begin
      out_lanes <= pack;
      out_cnt   <= pack_cnt;
      out_last  <= 1'b0;
      out_done  <= 1'b0;
      out_trunc <= 1'b0;
    end else if (cmd.flush_final) begin
      out_lanes <= pack;
      out_cnt   <= pack_cnt;
      out_last  <= 1'b1;
      out_done  <= cmd.res_done;
      out_trunc <= 1'b0;
    end else if (cmd.emit) begin
      out_lanes    <= {{PAD_W{1'b0}}, (cmd.put_lit ? in_byte : 8'd0)};
      out_cnt      <= cmd.put_lit ? lzb_pkg::CNT_W'(1) : '0;
      out_last     <= 1'b1;
      out_done     <= cmd.res_done;
      out_trunc    <= cmd.res_trunc;
    end
  end

endmodule

[sv/lz_backref_byte_decompressor.sv]
// lz_backref_byte_decompressor: top level, LZ77-style byte decompressor.
// Depends on lzb_pkg, lzb_ctrl, lzb_datapath (which holds lzb_ram).
//
//   channel  dir  payload                                   accept
//   s_*      in   tdata[7:0] in_byte, tlast block_end       s_tvalid & s_tready
//   m_*      out  tdata bytes+count, tlast run_last,        m_tvalid & m_tready
//                 tuser done/truncated
//
// A back-reference count item with N > 0 bytes to copy holds s_tready low after it is
// accepted while it copies one byte per cycle through the single history read port,
// unless a blocked output stalls it, and ceil(N/4) results leave for that copy.
// s_tready is low while a copy runs and while a finished result cannot move on.
// Reset is synchronous; history needs no clearing, so items are taken right after.
`timescale 1ns / 1ps

module lz_backref_byte_decompressor #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // [7:0] in_byte
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2, [31:24] out_byte3,
  // [34:32] bytes_valid, rest zero
  output logic [lzb_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  output logic [1:0]                        m_tuser   // [0] block_done, [1] truncated
);

  lzb_pkg::lzb_cmd_t          cmd;
  lzb_pkg::lzb_sts_t          sts;
  lzb_pkg::lane_vec_t         out_lanes;
  logic [lzb_pkg::CNT_W-1:0]  out_cnt;
  logic                       out_done;
  logic                       out_trunc;

  lzb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzb_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_lanes (out_lanes),
    .out_cnt   (out_cnt),
    .out_last  (m_tlast),
    .out_done  (out_done),
    .out_trunc (out_trunc)
  );

  assign m_tdata = lzb_pkg::OUT_TDATA_W'({out_cnt, out_lanes});
  assign m_tuser[lzb_pkg::TUSER_DONE]  = out_done;
  assign m_tuser[lzb_pkg::TUSER_TRUNC] = out_trunc;

endmodule

[sv/lzb_checker.sv]
// lzb_checker: port-level assertions for lz_backref_byte_decompressor, with bind.
// Depends on lzb_pkg.
`timescale 1ns / 1ps

module lzb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lzb_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tlast,
  input logic [1:0]                      m_tuser
);

  localparam int CNT_LO = lzb_pkg::OUT_LANES * 8;

  logic [lzb_pkg::CNT_W-1:0] cnt;
  assign cnt = m_tdata[CNT_LO +: lzb_pkg::CNT_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt <= lzb_pkg::CNT_W'(lzb_pkg::OUT_LANES))
    else $error("bytes_valid out of range");

  a_mid_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> cnt == lzb_pkg::CNT_W'(lzb_pkg::OUT_LANES))
    else $error("non-final result not full");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[lzb_pkg::TUSER_DONE] || m_tuser[lzb_pkg::TUSER_TRUNC])
      |-> m_tlast && m_tuser[lzb_pkg::TUSER_DONE])
    else $error("block flags on wrong result");

  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cnt == '0 |-> m_tuser[lzb_pkg::TUSER_DONE])
    else $error("empty result without block end");

endmodule

bind lz_backref_byte_decompressor lzb_checker u_lzb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

[test/lzb_stream_checker.sv]
// lzb_stream_checker: watches both streams of the LZ back-reference decompressor,
// decodes every accepted input item itself and compares each output item in order.
// Depends on lzb_pkg for lane count, parse phases and the tuser bit positions.
`timescale 1ns / 1ps

module lzb_stream_checker
  import lzb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tlast,
  input  logic [1:0]             m_tuser,
  output int                     errors,
  output int                     pending,
  output int                     results_checked,
  output int                     blocks_closed,
  output int                     blocks_truncated
);

  typedef struct {
    lane_vec_t          lanes;
    logic [CNT_W-1:0]   count;
    logic               run_last;
    logic               done;
    logic               trunc;
  } out_chunk_t;

  out_chunk_t expected_chunks[$];
  logic [7:0] made_bytes[$];

  logic [7:0] history [0:127];
  logic [6:0] wr_ptr;
  logic [7:0] produced;
  logic [1:0] phase;
  logic [6:0] ref_off;
  logic [6:0] lit_left;

  task automatic restart_block();
    wr_ptr = '0;
    produced = '0;
    phase = PH_HEADER;
    ref_off = '0;
    lit_left = '0;
  endtask

  task automatic put_byte(input logic [7:0] v);
    history[wr_ptr] = v;
    wr_ptr = wr_ptr + 7'd1;
    if (produced < PRODUCED_SAT) produced = produced + 8'd1;
    made_bytes.insert(made_bytes.size(), v);
  endtask

  task automatic decode_item(input logic [7:0] b, input logic blk_end);
    int         i;
    int         r;
    int         l;
    int         n;
    int         n_res;
    logic       trunc;
    logic [6:0] src;
    out_chunk_t c;
    made_bytes = {};
    trunc = 1'b0;
    case (phase)
      PH_COUNT: begin
        if (ref_off != 7'd0 && produced >= {1'b0, ref_off}) begin
          for (i = 0; i < b; i++) begin
            src = wr_ptr - ref_off;
            put_byte(history[src]);
          end
        end
        phase = PH_HEADER;
      end
      PH_LITERAL: begin
        put_byte(b);
        if (lit_left > 7'd0) lit_left = lit_left - 7'd1;
        if (lit_left == 7'd0) phase = PH_HEADER;
      end
      default: begin
        if (b[REF_FLAG_BIT]) begin
          ref_off = b[6:0];
          phase = PH_COUNT;
        end else if (b != 8'd0) begin
          lit_left = b[6:0] & LOW7[6:0];
          phase = PH_LITERAL;
        end
      end
    endcase
    if (blk_end) begin
      trunc = (phase != PH_HEADER);
      restart_block();
    end
    n = made_bytes.size();
    n_res = (n + OUT_LANES - 1) / OUT_LANES;
    if (n_res == 0 && blk_end) n_res = 1;
    for (r = 0; r < n_res; r++) begin
      c.lanes = '0;
      c.count = '0;
      for (l = 0; l < OUT_LANES; l++) begin
        if (r * OUT_LANES + l < n) begin
          c.lanes[l] = made_bytes[r * OUT_LANES + l];
          c.count = c.count + CNT_W'(1);
        end
      end
      c.run_last = (r == n_res - 1);
      c.done = c.run_last && blk_end;
      c.trunc = c.run_last && trunc;
      expected_chunks.insert(expected_chunks.size(), c);
    end
    if (blk_end) begin
      blocks_closed++;
      if (trunc) blocks_truncated++;
    end
  endtask

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    out_chunk_t c;
    int         l;
    if (expected_chunks.size() == 0) begin
      $error("output item with nothing expected: tdata %h", m_tdata);
      errors++;
      return;
    end
    c = expected_chunks.pop_front();
    results_checked++;
    for (l = 0; l < OUT_LANES; l++)
      check_field($sformatf("out_byte%0d", l), 9'(c.lanes[l]), 9'(m_tdata[8*l +: 8]));
    check_field("bytes_valid", 9'(c.count), 9'(m_tdata[8*OUT_LANES +: CNT_W]));
    check_field("run_last", 9'(c.run_last), 9'(m_tlast));
    check_field("block_done", 9'(c.done), 9'(m_tuser[TUSER_DONE]));
    check_field("truncated", 9'(c.trunc), 9'(m_tuser[TUSER_TRUNC]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_block();
      expected_chunks = {};
      errors = 0;
      results_checked = 0;
      blocks_closed = 0;
      blocks_truncated = 0;
    end else begin
      if (s_tvalid && s_tready) decode_item(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result();
    end
    pending <= expected_chunks.size();
  end

endmodule

[test/tb_lz_backref_byte_decompressor.sv]
// tb_lz_backref_byte_decompressor: stimulus and verdict for the LZ decompressor.
// Directed tokens, then random blocks under bursty input and a stalling receiver.
// Depends on lzb_pkg, the decompressor RTL and lzb_stream_checker.
`timescale 1ns / 1ps

module tb_lz_backref_byte_decompressor;
  import lzb_pkg::*;

  localparam int RANDOM_ITEMS = 230;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 60;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } comp_byte_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic [1:0]             m_tuser;

  int errors;
  int pending;
  int results_checked;
  int blocks_closed;
  int blocks_truncated;

  comp_byte_t stream_q[$];
  int         items_sent;
  int         directed_len;
  logic       hold_done;

  lz_backref_byte_decompressor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  lzb_stream_checker u_stream_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .m_tuser          (m_tuser),
    .errors           (errors),
    .pending          (pending),
    .results_checked  (results_checked),
    .blocks_closed    (blocks_closed),
    .blocks_truncated (blocks_truncated)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] backref_hdr(input int off);
    return {1'b1, 7'(off)};
  endfunction

  function automatic logic [7:0] literal_hdr(input int len);
    return {1'b0, 7'(len)};
  endfunction

  task automatic push_byte(input logic [7:0] d, input logic last);
    comp_byte_t c;
    c.data = d;
    c.last = last;
    stream_q.insert(stream_q.size(), c);
  endtask

  task automatic push_literals(input int len);
    int i;
    push_byte(literal_hdr(len), 1'b0);
    for (i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Well-formed tokens with random content; some blocks end inside a token,
  // some close on a bare zero header, a few tokens are raw noise.
  task automatic add_random_block();
    int n_tok;
    int cut;
    int t;
    int i;
    int kind;
    int len;
    int off;
    int cnt;
    int prod;
    int lim;
    prod = 0;
    n_tok = $urandom_range(1, 8);
    cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n_tok - 1) : -1;
    for (t = 0; t < n_tok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 10);
        if (t == cut) begin
          push_byte(literal_hdr(len), 1'b0);
          for (i = 0; i < $urandom_range(0, len - 1); i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
          stream_q[$].last = 1'b1;
          return;
        end
        push_literals(len);
        prod += len;
      end else if (kind < 95) begin
        lim = (prod < 127) ? prod : 127;
        off = (lim > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(1, lim)
                                                     : $urandom_range(0, 127);
        push_byte(backref_hdr(off), t == cut);
        if (t == cut) return;
        cnt = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        push_byte(8'(cnt), 1'b0);
        if (off != 0 && prod >= off) prod += cnt;
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if ($urandom_range(0, 9) == 0) push_byte(8'h00, 1'b0);
    stream_q[$].last = 1'b1;
  endtask

  task automatic build_stream();
    // zero literal header, then four literals: 00, FF, AA and 55
    push_byte(literal_hdr(0), 1'b0);
    push_byte(literal_hdr(4), 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    // self-overlapping copy, plain copy, offset zero, offset past output, zero count
    push_byte(backref_hdr(1), 1'b0);
    push_byte(8'd6, 1'b0);
    push_byte(backref_hdr(4), 1'b0);
    push_byte(8'd3, 1'b0);
    push_byte(backref_hdr(0), 1'b0);
    push_byte(8'd5, 1'b0);
    push_byte(backref_hdr(127), 1'b0);
    push_byte(8'd2, 1'b0);
    push_byte(backref_hdr(2), 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(literal_hdr(1), 1'b0);
    push_byte(8'h7F, 1'b1);
    // block ends awaiting a count, then owing literals, then on an empty item
    push_byte(backref_hdr(5), 1'b1);
    push_byte(literal_hdr(127), 1'b0);
    push_byte(8'h11, 1'b1);
    push_byte(literal_hdr(0), 1'b1);
    // longest copy
    push_byte(literal_hdr(1), 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(backref_hdr(1), 1'b0);
    push_byte(8'hFF, 1'b1);
    directed_len = stream_q.size();
    while (stream_q.size() < directed_len + RANDOM_ITEMS) add_random_block();
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int mode;
    int span;
    int k;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (k % 3 != 0);
          default: m_tready <= (k % 8 == 7);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL lz_backref_byte_decompressor");
    $finish;
  end

  initial begin
    int idx;
    int burst;
    int gap;
    items_sent = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    build_stream();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idx = 0;
    while (idx < stream_q.size()) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && idx < stream_q.size()) begin
        s_tvalid <= 1'b1;
        s_tdata <= stream_q[idx].data;
        s_tlast <= stream_q[idx].last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        idx++;
        items_sent = idx;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d input items (%0d directed), %0d output items checked",
             items_sent, directed_len, results_checked);
    $display("run: %0d blocks closed, %0d of them truncated, long receiver hold-off %s",
             blocks_closed, blocks_truncated, hold_done ? "done" : "not reached");
    if (errors == 0 && pending == 0)
      $display("PASS lz_backref_byte_decompressor");
    else
      $display("FAIL lz_backref_byte_decompressor");
    $finish;
  end

endmodule
